/* rtl/toy_spn_cipher_9bit_assert.svh */
// Assertion macros for the toy SPN cipher block.
`ifndef TOY_SPN_CIPHER_9BIT_ASSERT_SVH
`define TOY_SPN_CIPHER_9BIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TSPN_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tspn assertion failed");
`define TSPN_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tspn assertion failed during reset");
`else
`define TSPN_ASSERT(label, prop)
`define TSPN_ASSERT_ALWAYS(label, prop)
`endif
`endif

/* rtl/tspn_pkg.sv */
// Shared constants and helper functions for the toy SPN cipher.
`default_nettype none
package tspn_pkg;

  localparam int unsigned WordW   = 9;
  localparam int unsigned GroupW  = 3;
  localparam int unsigned NumGrp  = WordW / GroupW;

  localparam bit KindEncrypt = 1'b0;
  localparam bit KindDecrypt = 1'b1;

  typedef logic [WordW-1:0]  word_t;
  typedef logic [GroupW-1:0] group_t;

  localparam group_t SBOX_FWD [8] = '{3'd5, 3'd0, 3'd1, 3'd4, 3'd7, 3'd2, 3'd6, 3'd3};
  localparam group_t SBOX_INV [8] = '{3'd1, 3'd2, 3'd5, 3'd7, 3'd3, 3'd0, 3'd6, 3'd4};
  localparam int unsigned BIT_PERM [WordW] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

  function automatic word_t sbox_fwd_word(input word_t w);
    word_t r;
    r = '0;
    for (int g = 0; g < NumGrp; g++) begin
      r[g*GroupW +: GroupW] = SBOX_FWD[w[g*GroupW +: GroupW]];
    end
    return r;
  endfunction

  function automatic word_t sbox_inv_word(input word_t w);
    word_t r;
    r = '0;
    for (int g = 0; g < NumGrp; g++) begin
      r[g*GroupW +: GroupW] = SBOX_INV[w[g*GroupW +: GroupW]];
    end
    return r;
  endfunction

  // Bit 3b+j moves to bit 3j+b; the wiring is its own inverse.
  function automatic word_t transpose_word(input word_t w);
    word_t r;
    r = '0;
    for (int i = 0; i < WordW; i++) begin
      r[BIT_PERM[i]] = w[i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/tspn_enc.sv */
// Three-round encryption datapath of the toy SPN cipher.
`default_nettype none
module tspn_enc (
  input  wire tspn_pkg::word_t key,
  input  wire tspn_pkg::word_t data_in,
  output tspn_pkg::word_t      data_out
);

  tspn_pkg::word_t r1;
  tspn_pkg::word_t r2;
  tspn_pkg::word_t r3;

  assign r1 = tspn_pkg::transpose_word(tspn_pkg::sbox_fwd_word(data_in ^ key));
  assign r2 = tspn_pkg::transpose_word(tspn_pkg::sbox_fwd_word(r1 ^ key));
  assign r3 = tspn_pkg::sbox_fwd_word(r2 ^ key);
  assign data_out = r3 ^ key;

endmodule
`default_nettype wire

/* rtl/tspn_dec.sv */
// Three-round decryption datapath of the toy SPN cipher.
`default_nettype none
module tspn_dec (
  input  wire tspn_pkg::word_t key,
  input  wire tspn_pkg::word_t data_in,
  output tspn_pkg::word_t      data_out
);

  tspn_pkg::word_t r1;
  tspn_pkg::word_t r2;
  tspn_pkg::word_t r3;

  assign r1 = tspn_pkg::sbox_inv_word(data_in ^ key) ^ key;
  assign r2 = tspn_pkg::sbox_inv_word(tspn_pkg::transpose_word(r1)) ^ key;
  assign r3 = tspn_pkg::sbox_inv_word(tspn_pkg::transpose_word(r2)) ^ key;
  assign data_out = r3;

endmodule
`default_nettype wire

/* rtl/toy_spn_cipher_9bit.sv */
// Top level of the toy 9-bit SPN cipher: input, key and result registers.
`default_nettype none
`include "toy_spn_cipher_9bit_assert.svh"
// The block takes one word per clock cycle and never raises busy. A word
// whose transfer happens at one edge is captured in the input register,
// passes the three cipher rounds combinationally, and its result is
// registered in the result register and appears on out_result_word with
// out_valid high for one cycle. The receiver cannot stall, so results must
// be taken when shown. The user must write the key through cfg_wr_en and
// cfg_wr_data while the block is idle; the block itself does not enforce it.
module toy_spn_cipher_9bit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic            in_kind,
  input  wire tspn_pkg::word_t in_data_word,
  output logic                 out_valid,
  output tspn_pkg::word_t      out_result_word,
  input  wire logic            cfg_wr_en,
  input  wire tspn_pkg::word_t cfg_wr_data
);

  logic            in_valid_r;
  logic            in_kind_r;
  tspn_pkg::word_t in_data_r;
  tspn_pkg::word_t key_r;
  logic            out_valid_r;
  tspn_pkg::word_t result_r;
  tspn_pkg::word_t enc_word;
  tspn_pkg::word_t dec_word;
  tspn_pkg::word_t result_nxt;
  logic            accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      key_r       <= '0;
    end else begin
      in_valid_r  <= accept;
      out_valid_r <= in_valid_r;
      if (cfg_wr_en) begin
        key_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_kind_r <= in_kind;
      in_data_r <= in_data_word;
    end
    result_r <= result_nxt;
  end

  tspn_enc u_enc (
    .key      (key_r),
    .data_in  (in_data_r),
    .data_out (enc_word)
  );

  tspn_dec u_dec (
    .key      (key_r),
    .data_in  (in_data_r),
    .data_out (dec_word)
  );

  assign result_nxt      = (in_kind_r == tspn_pkg::KindDecrypt) ? dec_word : enc_word;
  assign out_valid       = out_valid_r;
  assign out_result_word = result_r;

  `TSPN_ASSERT(a_result_follows, in_valid_r |=> out_valid)
  `TSPN_ASSERT(a_no_spurious, !in_valid_r |=> !out_valid)
  `TSPN_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid && !in_valid_r)

endmodule
`default_nettype wire
